@@ rtl/core/mplm_pkg.sv @@
`default_nettype none

package mplm_pkg;

	// Field widths of the sample stream and the results.
	localparam int CHAN_W     = 3;
	localparam int CHAN_COUNT = 1 << CHAN_W;
	localparam int SAMPLE_W   = 24;
	localparam int LEVEL_W    = 23;
	localparam int COEF_W     = 16;
	localparam int DB_W       = 16;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 23;

	localparam logic [CFG_IDX_W-1:0] REG_DECAY_COEF  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR_LEVEL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR_DB    = 2'd2;

	// Register reset values: decay 3/65536, floor at 1e-3 of full scale, -60 dB.
	localparam logic [COEF_W-1:0]         DECAY_COEF_RST  = 16'd3;
	localparam logic [LEVEL_W-1:0]        FLOOR_LEVEL_RST = 23'd8389;
	localparam logic signed [DB_W-1:0]    FLOOR_DB_RST    = -16'sd15360;

	// Largest magnitude a sample can take once the most negative code saturates.
	localparam logic [LEVEL_W-1:0] FULL_MAX = {LEVEL_W{1'b1}};

	// Logarithm format: bit position of the leading one, then Q16 fraction.
	localparam int POS_W  = 5;
	localparam int FRAC_W = 16;
	localparam int LOG_W  = POS_W + FRAC_W;
	// Normalized mantissa is Q30 in [1, 2).
	localparam int MANT_W = 31;

	// Level handed from the level stage to the decibel pipeline.
	typedef struct packed {
		logic [CHAN_W-1:0]  chan;
		logic [LEVEL_W-1:0] level;
		logic               above;
	} level_req_t;

	// Position of the highest set bit; zero for a zero input.
	function automatic logic [POS_W-1:0] top_bit_pos(input logic [LEVEL_W-1:0] v);
		logic [POS_W-1:0] pos;
		pos = '0;
		for (int i = 0; i < LEVEL_W; i++) begin
			if (v[i]) begin
				pos = POS_W'(i);
			end
		end
		return pos;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/multichannel_peak_level_meter_core.sv @@
`default_nettype none

// Per-channel peak meter with instant attack and exponential release. Each
// transaction carries a Q1.23 sample and its channel; the block returns one
// result per transaction in arrival order: the channel, its new Q0.23 level and
// that level in dBFS (Q8.8), or floor_db at or below floor_level. A new
// transaction can be taken in every cycle unless the output stalls, and each
// result passes the input, level, log2 pipeline, product and output registers.
// The level update for a channel is a read-modify-write of its register, so
// back-to-back samples of the same channel need no gaps; the latency comes from
// the log2 pipeline, which resolves one fraction bit per stage by squaring the
// mantissa with one multiplier per stage. Registers are written through the
// configuration port, index 0 decay_coef, 1 floor_level, 2 floor_db; other
// indexes are ignored. Write them only while no transaction is in flight.
// Channels at or above NUM_CHANNELS leave all levels untouched and report a
// level of zero at floor_db.

module multichannel_peak_level_meter_core
	import mplm_pkg::*;
#(
	parameter int NUM_CHANNELS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [CHAN_W-1:0]         chan_index,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [CHAN_W-1:0]         chan_out,
	output logic [LEVEL_W-1:0]        peak_level,
	output logic signed [DB_W-1:0]    level_db
);

	// Only channels reachable by the index field get a level register.
	localparam int NUM_LEVELS = (NUM_CHANNELS < CHAN_COUNT) ? NUM_CHANNELS : CHAN_COUNT;
	localparam int IDX_W      = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
	localparam int REL_W      = LEVEL_W + COEF_W;
	localparam logic [REL_W-1:0] REL_ROUND = REL_W'(1) << (COEF_W - 1);

	logic [COEF_W-1:0]      decay_coef_q;
	logic [LEVEL_W-1:0]     floor_level_q;
	logic signed [DB_W-1:0] floor_db_q;

	logic [LEVEL_W-1:0]     chan_levels_q [0:NUM_LEVELS-1];

	logic                      vld_s1;
	logic                      ld_s1;
	logic [CHAN_W-1:0]         chan_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;

	logic                   vld_s2;
	logic                   ld_s2;
	level_req_t             req_s2;
	level_req_t             req_nxt;

	logic                   pipe_stall;
	logic                   in_range;
	logic [IDX_W-1:0]       level_idx;
	logic [SAMPLE_W-1:0]    sample_neg;
	logic [LEVEL_W-1:0]     mag;
	logic [LEVEL_W-1:0]     old_level;
	logic [LEVEL_W-1:0]     rel_gap;
	logic [REL_W-1:0]       rel_sum;
	logic [LEVEL_W-1:0]     rel_step;
	logic [LEVEL_W-1:0]     new_level;

	// Configuration registers; the port never back-pressures.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_coef_q  <= DECAY_COEF_RST;
			floor_level_q <= FLOOR_LEVEL_RST;
			floor_db_q    <= FLOOR_DB_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DECAY_COEF:  decay_coef_q  <= cfg_data[COEF_W-1:0];
				REG_FLOOR_LEVEL: floor_level_q <= cfg_data[LEVEL_W-1:0];
				REG_FLOOR_DB:    floor_db_q    <= cfg_data[DB_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake: each stage loads when empty or when its content moves on.
	assign ld_s2    = !vld_s2 || !pipe_stall;
	assign ld_s1    = !vld_s1 || ld_s2;
	assign in_stall = !ld_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (ld_s1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1 && in_valid) begin
			chan_s1   <= chan_index;
			sample_s1 <= sample_in;
		end
	end

	// Sample magnitude, with the most negative code saturating to full scale.
	assign sample_neg = SAMPLE_W'(0) - sample_s1;

	always_comb begin
		if (!sample_s1[SAMPLE_W-1]) begin
			mag = sample_s1[LEVEL_W-1:0];
		end else if (sample_neg[SAMPLE_W-1]) begin
			mag = FULL_MAX;
		end else begin
			mag = sample_neg[LEVEL_W-1:0];
		end
	end

	// Level update: jump up to the magnitude, or close a rounded fraction of the gap.
	assign in_range  = {1'b0, chan_s1} < (CHAN_W + 1)'(NUM_LEVELS);
	assign level_idx = chan_s1[IDX_W-1:0];
	assign old_level = in_range ? chan_levels_q[level_idx] : '0;
	assign rel_gap   = old_level - mag;
	assign rel_sum   = REL_W'(rel_gap) * REL_W'(decay_coef_q) + REL_ROUND;
	assign rel_step  = rel_sum[REL_W-1:COEF_W];
	assign new_level = (mag > old_level) ? mag : old_level - rel_step;

	always_comb begin
		req_nxt.chan  = chan_s1;
		req_nxt.level = in_range ? new_level : '0;
		req_nxt.above = in_range && (new_level > floor_level_q);
	end

	// Per-channel levels are committed as the transaction leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEVELS; i++) begin
				chan_levels_q[i] <= '0;
			end
		end else if (vld_s1 && ld_s2 && in_range) begin
			chan_levels_q[level_idx] <= new_level;
		end
	end

	// Level register in front of the decibel pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (ld_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s2 && vld_s1) begin
			req_s2 <= req_nxt;
		end
	end

	mplm_db_pipe u_db_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (vld_s2),
		.req_stall  (pipe_stall),
		.req        (req_s2),
		.floor_db   (floor_db_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.chan_out   (chan_out),
		.peak_level (peak_level),
		.level_db   (level_db)
	);

endmodule

`default_nettype wire

@@ rtl/core/mplm_db_pipe.sv @@
`default_nettype none

module mplm_db_pipe
	import mplm_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  level_req_t                req,
	input  logic signed [DB_W-1:0]    floor_db,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [CHAN_W-1:0]         chan_out,
	output logic [LEVEL_W-1:0]        peak_level,
	output logic signed [DB_W-1:0]    level_db
);

	localparam int NSQ    = FRAC_W;
	localparam int PROD_W = 40;
	localparam int MAG_W  = 16;

	// 20*log10(2) in Q16, and the log2 of full scale in Q16.
	localparam logic [PROD_W-1:0] DB_K     = 40'd394566;
	localparam logic [LOG_W-1:0]  LOG_TOP  = 21'd1507328;
	localparam logic [PROD_W-1:0] DB_ROUND = 40'd8388608;
	localparam logic [MAG_W-1:0]  DB_SAT   = 16'd32768;

	typedef struct packed {
		logic [CHAN_W-1:0]  chan;
		logic [LEVEL_W-1:0] level;
		logic               above;
		logic [POS_W-1:0]   pos;
		logic [MANT_W-1:0]  mant;
		logic [FRAC_W-1:0]  frac;
	} log_stage_t;

	typedef struct packed {
		logic [CHAN_W-1:0]  chan;
		logic [LEVEL_W-1:0] level;
		logic               above;
		logic [PROD_W-1:0]  prod;
	} prod_stage_t;

	// Stage 0 holds the normalized mantissa, stage k the mantissa after k squarings.
	log_stage_t  log_s    [0:NSQ];
	log_stage_t  log_nxt  [0:NSQ];
	logic        log_vld_s[0:NSQ];
	logic        log_ld   [0:NSQ];

	prod_stage_t prod_s;
	prod_stage_t prod_nxt;
	logic        prod_vld_s;
	logic        prod_ld;

	logic                   out_vld_q;
	logic                   out_ld;
	logic [CHAN_W-1:0]      out_chan_q;
	logic [LEVEL_W-1:0]     out_level_q;
	logic signed [DB_W-1:0] out_db_q;

	logic [LOG_W-1:0]       log_val;
	logic [LOG_W-1:0]       log_gap;
	logic [PROD_W-1:0]      db_round;
	logic [MAG_W-1:0]       db_mag;
	logic [MAG_W-1:0]       db_mag_sat;
	logic signed [DB_W-1:0] db_val;

	// A stage loads when it is empty or its content moves on in the same cycle.
	assign out_ld    = !out_vld_q || !out_stall;
	assign prod_ld   = !prod_vld_s || out_ld;
	assign req_stall = !log_ld[0];

	for (genvar k = 0; k <= NSQ; k++) begin : g_stage
		logic vld_in;

		if (k == NSQ) begin : g_last_ld
			assign log_ld[k] = !log_vld_s[k] || prod_ld;
		end else begin : g_mid_ld
			assign log_ld[k] = !log_vld_s[k] || log_ld[k+1];
		end

		if (k == 0) begin : g_norm
			assign vld_in = req_valid;

			// Leading-one search and left shift into Q30.
			always_comb begin
				log_nxt[k].chan  = req.chan;
				log_nxt[k].level = req.level;
				log_nxt[k].above = req.above;
				log_nxt[k].pos   = top_bit_pos(req.level);
				log_nxt[k].mant  = MANT_W'(req.level) <<
					(POS_W'(MANT_W - 1) - log_nxt[k].pos);
				log_nxt[k].frac  = '0;
			end
		end else begin : g_square
			logic [2*MANT_W-1:0] sq_prod;
			logic [MANT_W:0]     sq_top;

			assign vld_in  = log_vld_s[k-1];
			assign sq_prod = log_s[k-1].mant * log_s[k-1].mant;
			assign sq_top  = sq_prod[2*MANT_W-1:MANT_W-1];

			// One fraction bit per squaring; renormalize when the square reaches 2.
			always_comb begin
				log_nxt[k]      = log_s[k-1];
				log_nxt[k].frac = {log_s[k-1].frac[FRAC_W-2:0], sq_top[MANT_W]};
				log_nxt[k].mant = sq_top[MANT_W] ? sq_top[MANT_W:1] : sq_top[MANT_W-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				log_vld_s[k] <= 1'b0;
			end else if (log_ld[k]) begin
				log_vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (log_ld[k] && vld_in) begin
				log_s[k] <= log_nxt[k];
			end
		end
	end

	// Distance below full scale in Q16, scaled to decibels.
	assign log_val = {log_s[NSQ].pos, log_s[NSQ].frac};
	assign log_gap = LOG_TOP - log_val;

	always_comb begin
		prod_nxt.chan  = log_s[NSQ].chan;
		prod_nxt.level = log_s[NSQ].level;
		prod_nxt.above = log_s[NSQ].above;
		prod_nxt.prod  = PROD_W'(log_gap) * DB_K;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_s <= 1'b0;
		end else if (prod_ld) begin
			prod_vld_s <= log_vld_s[NSQ];
		end
	end

	always_ff @(posedge clk) begin
		if (prod_ld && log_vld_s[NSQ]) begin
			prod_s <= prod_nxt;
		end
	end

	// Round, saturate at -128 dB, negate, and pick the floor value at or below the floor.
	assign db_round   = prod_s.prod + DB_ROUND;
	assign db_mag     = db_round[PROD_W-1:PROD_W-MAG_W];
	assign db_mag_sat = (db_mag > DB_SAT) ? DB_SAT : db_mag;
	assign db_val     = DB_W'(MAG_W'(0) - db_mag_sat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_ld) begin
			out_vld_q <= prod_vld_s;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld && prod_vld_s) begin
			out_chan_q  <= prod_s.chan;
			out_level_q <= prod_s.level;
			out_db_q    <= prod_s.above ? db_val : floor_db;
		end
	end

	assign out_valid  = out_vld_q;
	assign chan_out   = out_chan_q;
	assign peak_level = out_level_q;
	assign level_db   = out_db_q;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none

module tb;
	import mplm_pkg::*;

	// The unused register index must be ignored by the block.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int RAND_PHASES   = 6;
	localparam int PHASE_ITEMS   = 322;
	localparam int SETTLE_CYCLES = 40;
	localparam longint unsigned DB_PER_OCTAVE_Q16 = 394566;

	typedef struct packed {
		logic [CHAN_W-1:0]          chan;
		logic signed [SAMPLE_W-1:0] sample;
	} sample_item_t;

	typedef struct packed {
		logic [CHAN_W-1:0]      chan;
		logic [LEVEL_W-1:0]     level;
		logic signed [DB_W-1:0] db;
	} meter_reading_t;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic [CHAN_W-1:0]          chan_index;
	logic signed [SAMPLE_W-1:0] sample_in;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_DATA_W-1:0]      cfg_data;
	logic                       out_valid;
	logic                       out_stall;
	logic [CHAN_W-1:0]          chan_out;
	logic [LEVEL_W-1:0]         peak_level;
	logic signed [DB_W-1:0]     level_db;

	// Samples waiting to be sent and readings waiting to come back.
	sample_item_t   pending_samples[$];
	meter_reading_t expected_readings[$];

	// Shadow copy of the channel levels and the meter settings.
	logic [LEVEL_W-1:0]     chan_peak[CHAN_COUNT];
	logic [COEF_W-1:0]      release_coef;
	logic [LEVEL_W-1:0]     floor_lin;
	logic signed [DB_W-1:0] floor_q88;

	bit           in_fire;
	int           send_gap;
	int           send_burst;
	int           stall_left;
	int           stall_burst;
	int           mismatch_count;
	sample_item_t next_item;

	multichannel_peak_level_meter_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.chan_index (chan_index),
		.sample_in  (sample_in),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.chan_out   (chan_out),
		.peak_level (peak_level),
		.level_db   (level_db)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#20_000_000;
		$display("tb: FAIL");
		$finish;
	end

	// Gap length: mostly none, some short, a few long, with idle-free bursts.
	function automatic int pick_gap(inout int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0) begin
			burst = $urandom_range(20, 80);
			return 0;
		end
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return 0;
			6, 7, 8: return $urandom_range(1, 3);
			default: return $urandom_range(8, 40);
		endcase
	endfunction

	// Base-2 logarithm in Q16, fraction found by repeated squaring of a Q30 mantissa.
	function automatic logic [LOG_W-1:0] log2_fixed(input longint unsigned v);
		int unsigned       pos;
		longint unsigned   mant;
		logic [FRAC_W-1:0] frac;
		pos = 0;
		frac = '0;
		for (int i = 0; i < LEVEL_W; i++) begin
			if (v[i]) begin
				pos = i;
			end
		end
		mant = v << (30 - pos);
		for (int i = 0; i < FRAC_W; i++) begin
			mant = (mant * mant) >> 30;
			frac = {frac[FRAC_W-2:0], 1'b0};
			if (mant >= (64'd1 << 31)) begin
				frac[0] = 1'b1;
				mant = mant >> 1;
			end
		end
		return {POS_W'(pos), frac};
	endfunction

	// Level in dBFS, Q8.8, held at the floor value at or below the floor level.
	function automatic logic signed [DB_W-1:0] level_to_dbfs(input longint unsigned lvl);
		longint unsigned below_full;
		longint unsigned atten;
		int              db_i;
		if (lvl <= floor_lin || lvl == 0) begin
			return floor_q88;
		end
		below_full = (64'd23 << 16) - 64'(log2_fixed(lvl));
		atten = (below_full * DB_PER_OCTAVE_Q16 + (64'd1 << 23)) >> 24;
		if (atten > 32768) begin
			atten = 32768;
		end
		db_i = -int'(atten);
		return db_i[DB_W-1:0];
	endfunction

	// Instant attack, rounded exponential release, then the dB conversion.
	function automatic meter_reading_t meter_update(input logic [CHAN_W-1:0] ch,
			input logic signed [SAMPLE_W-1:0] s);
		int              mag_i;
		longint unsigned mag;
		longint unsigned lvl;
		meter_reading_t  r;
		mag_i = int'(s);
		if (mag_i < 0) begin
			mag_i = -mag_i;
		end
		mag = mag_i;
		if (mag > FULL_MAX) begin
			mag = FULL_MAX;
		end
		lvl = chan_peak[ch];
		if (mag > lvl) begin
			lvl = mag;
		end else begin
			lvl = lvl - (((lvl - mag) * release_coef + 32768) >> 16);
		end
		chan_peak[ch] = lvl[LEVEL_W-1:0];
		r.chan = ch;
		r.level = lvl[LEVEL_W-1:0];
		r.db = level_to_dbfs(lvl);
		return r;
	endfunction

	// Random sample: full scale, small, extreme codes, or scaled down.
	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		logic signed [SAMPLE_W-1:0] s;
		s = SAMPLE_W'($urandom);
		case ($urandom_range(0, 9))
			0, 1, 2: ;
			3, 4: s = s >>> (SAMPLE_W - 8);
			5: begin
				case ($urandom_range(0, 5))
					0: s = 24'sh7FFFFF;
					1: s = 24'sh800000;
					2: s = 24'sh800001;
					3: s = 24'sd0;
					4: s = 24'sd1;
					default: s = -24'sd1;
				endcase
			end
			default: s = s >>> $urandom_range(1, SAMPLE_W - 1);
		endcase
		return s;
	endfunction

	task automatic push_sample(input logic [CHAN_W-1:0] ch, input logic signed [SAMPLE_W-1:0] s);
		sample_item_t it;
		it.chan = ch;
		it.sample = s;
		pending_samples.push_back(it);
	endtask

	// One register write; the shadow settings follow the accepted transaction.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		case (idx)
			REG_DECAY_COEF: release_coef = data[COEF_W-1:0];
			REG_FLOOR_LEVEL: floor_lin = data[LEVEL_W-1:0];
			REG_FLOOR_DB: floor_q88 = data[DB_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// The 16-bit registers get random upper bits, which the block must drop.
	task automatic set_meter(input int coef, input int floor_val, input int floor_dbv);
		write_reg(REG_DECAY_COEF, {7'($urandom), 16'(coef)});
		write_reg(REG_FLOOR_LEVEL, 23'(floor_val));
		write_reg(REG_FLOOR_DB, {7'($urandom), 16'(floor_dbv)});
	endtask

	// Hold off the sender until every reading is back, then let the pipeline settle.
	task automatic wait_idle();
		while (pending_samples.size() != 0 || in_valid || expected_readings.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Sample driver: holds a stalled transaction, otherwise sends the next one or idles.
	always @(negedge clk) begin
		if (!in_valid || in_fire) begin
			if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap--;
			end else if (pending_samples.size() > 0) begin
				next_item = pending_samples.pop_front();
				in_valid <= 1'b1;
				chan_index <= next_item.chan;
				sample_in <= next_item.sample;
				send_gap = pick_gap(send_burst);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result-side backpressure.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
			stall_left = pick_gap(stall_burst);
		end
	end

	// Monitor: predict on each accepted sample, check each accepted reading.
	always @(posedge clk) begin
		meter_reading_t exp_r;
		in_fire = in_valid && !in_stall;
		if (in_fire) begin
			expected_readings.push_back(meter_update(chan_index, sample_in));
		end
		if (out_valid && !out_stall) begin
			if (expected_readings.size() == 0) begin
				$error("unexpected reading: chan_out %0d peak_level %0d level_db %0d",
					chan_out, peak_level, level_db);
				mismatch_count++;
			end else begin
				exp_r = expected_readings.pop_front();
				if (chan_out !== exp_r.chan) begin
					$error("chan_out: expected %0d, got %0d", exp_r.chan, chan_out);
					mismatch_count++;
				end
				if (peak_level !== exp_r.level) begin
					$error("peak_level: expected %0d, got %0d", exp_r.level, peak_level);
					mismatch_count++;
				end
				if (level_db !== exp_r.db) begin
					$error("level_db: expected %0d, got %0d", exp_r.db, level_db);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		int                   count;
		int                   run_len;
		int                   coef;
		int                   floor_val;
		int                   floor_dbv;
		logic [CHAN_W-1:0]    hot_chan;
		logic [CHAN_W-1:0]    ch;
		arst_n = 1'b0;
		in_valid = 1'b0;
		chan_index = '0;
		sample_in = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_DECAY_COEF;
		cfg_data = '0;
		out_stall = 1'b0;
		in_fire = 1'b0;
		send_gap = 0;
		send_burst = 0;
		stall_left = 0;
		stall_burst = 0;
		mismatch_count = 0;
		release_coef = DECAY_COEF_RST;
		floor_lin = FLOOR_LEVEL_RST;
		floor_q88 = FLOOR_DB_RST;
		for (int i = 0; i < CHAN_COUNT; i++) begin
			chan_peak[i] = '0;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (5) @(posedge clk);

		// Reset settings: zero, full scale both ways, the saturating code, floor edges.
		push_sample(3'd0, 24'sd0);
		push_sample(3'd7, 24'sh7FFFFF);
		push_sample(3'd7, 24'sd0);
		push_sample(3'd2, 24'sh800000);
		push_sample(3'd3, -24'sd8388607);
		push_sample(3'd1, 24'sd1);
		push_sample(3'd1, -24'sd1);
		push_sample(3'd6, 24'sd8389);
		push_sample(3'd6, 24'sd8390);
		push_sample(3'd5, -24'sd8390);
		wait_idle();

		// Full-speed release, no floor: zero level and the saturated dB reading.
		write_reg(REG_UNUSED, 23'($urandom));
		set_meter(65535, 0, -32768);
		push_sample(3'd0, 24'sd0);
		push_sample(3'd4, 24'sd1);
		push_sample(3'd4, 24'sd0);
		push_sample(3'd7, -24'sd1);
		push_sample(3'd1, 24'sh7FFFFF);
		push_sample(3'd1, 24'sd4194304);
		push_sample(3'd1, 24'sh800000);
		wait_idle();

		// No release, floor at full scale, floor value of 0 dB.
		set_meter(0, 8388607, 0);
		push_sample(3'd2, 24'sd100);
		push_sample(3'd2, 24'sd0);
		push_sample(3'd3, 24'sh7FFFFF);
		wait_idle();

		// Random phases, each under its own settings.
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case ($urandom_range(0, 4))
				0: coef = 0;
				1: coef = 65535;
				2: coef = $urandom_range(1, 64);
				default: coef = $urandom_range(0, 65535);
			endcase
			case ($urandom_range(0, 4))
				0: floor_val = 0;
				1: floor_val = 8388607;
				2: floor_val = $urandom_range(0, 255);
				3: floor_val = 8389;
				default: floor_val = $urandom_range(0, 8388607);
			endcase
			case ($urandom_range(0, 3))
				0: floor_dbv = 0;
				1: floor_dbv = -32768;
				default: floor_dbv = -int'($urandom_range(0, 32768));
			endcase
			if ($urandom_range(0, 2) == 0) begin
				write_reg(REG_UNUSED, 23'($urandom));
			end
			set_meter(coef, floor_val, floor_dbv);
			hot_chan = CHAN_W'($urandom);
			count = 0;
			while (count < PHASE_ITEMS) begin
				if ($urandom_range(0, 3) == 0) begin
					// A loud hit followed by quiet samples on one channel, to walk the release.
					ch = CHAN_W'($urandom);
					push_sample(ch, rand_sample());
					run_len = $urandom_range(5, 30);
					for (int k = 0; k < run_len; k++) begin
						push_sample(ch, SAMPLE_W'($urandom) >>> $urandom_range(12, SAMPLE_W - 1));
					end
					count += run_len + 1;
				end else begin
					ch = $urandom_range(0, 1) ? hot_chan : CHAN_W'($urandom);
					push_sample(ch, rand_sample());
					count++;
				end
			end
			wait_idle();
		end

		if (mismatch_count == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
